// ===== design/rmsprop_element_update_macros.svh =====
// ----------------------------------------------------------------------------
// RMSprop element update assertion macros
// Shared concurrent assertion forms for the element update datapath.
// ----------------------------------------------------------------------------
`ifndef RMSPROP_ELEMENT_UPDATE_MACROS_SVH
`define RMSPROP_ELEMENT_UPDATE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define RMSU_ASSERT_IMP(label, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
`define RMSU_ASSERT_NEXT(label, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define RMSU_ASSERT_IMP(label, a, b)
`define RMSU_ASSERT_NEXT(label, a, b)
`endif
`endif

// ===== design/rmsu_pkg.sv =====
// ----------------------------------------------------------------------------
// RMSprop element update package
// Types and constants shared by the element update datapath.
// ----------------------------------------------------------------------------
package rmsu_pkg;

    localparam int FRAC_BITS = 16;
    localparam int SQ_STEPS = (32 + FRAC_BITS) / 2;
    localparam int DIV_STEPS = 32 + FRAC_BITS;

    localparam logic [1:0] REG_LEARN_RATE = 2'd0;
    localparam logic [1:0] REG_DECAY_FACTOR = 2'd1;
    localparam logic [1:0] REG_STABILITY_EPS = 2'd2;
    localparam logic [1:0] REG_L2_DECAY = 2'd3;

    localparam logic [15:0] LEARN_RATE_RESET = 16'd655;
    localparam logic [15:0] DECAY_FACTOR_RESET = 16'd64881;
    localparam logic [15:0] STABILITY_EPS_RESET = 16'd1;
    localparam logic [15:0] L2_DECAY_RESET = 16'd0;

    typedef struct packed {
        logic signed [31:0] gradient;
        logic signed [31:0] weight_in;
        logic [31:0]        sq_avg_in;
    } in_t;

    typedef struct packed {
        logic signed [31:0] weight_out;
        logic [31:0]        sq_avg_out;
        logic               saturated;
    } out_t;

    typedef struct packed {
        logic [15:0] learn_rate;
        logic [15:0] decay_factor;
        logic [15:0] stability_eps;
        logic [15:0] l2_decay;
    } cfg_t;

endpackage

// ===== design/rmsprop_element_update.sv =====
// ----------------------------------------------------------------------------
// RMSprop element update
// Requests pass product, decay, square, average, sqrt, divide and update stages.
// One request per cycle when not stalled; sqrt and divider run one bit per stage.
// Empty stages collapse, so a stalled output does not block free stages upstream.
// Asynchronous reset clears all valid bits and restores the config registers.
// ----------------------------------------------------------------------------
`include "rmsprop_element_update_macros.svh"

module rmsprop_element_update
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  rmsu_pkg::in_t   in_data,
    output logic            out_valid,
    input  logic            out_stall,
    output rmsu_pkg::out_t  out_data,
    input  logic            cfg_we,
    input  logic [1:0]      cfg_index,
    input  logic [15:0]     cfg_data
);

    localparam int ST_PROD = 0;
    localparam int ST_DECAY = 1;
    localparam int ST_SQ = 2;
    localparam int ST_GSQ = 3;
    localparam int ST_AVG = 4;
    localparam int ST_VN = 5;
    localparam int SQ_FIRST = 6;
    localparam int ST_DEN = SQ_FIRST + rmsu_pkg::SQ_STEPS;
    localparam int DIV_FIRST = ST_DEN + 1;
    localparam int ST_Q = DIV_FIRST + rmsu_pkg::DIV_STEPS;
    localparam int ST_STEP = ST_Q + 1;
    localparam int ST_W = ST_STEP + 1;
    localparam int NUM_STAGES = ST_W + 1;

    localparam logic signed [33:0] S32_MAX = 34'sh0_7FFF_FFFF;
    localparam logic signed [33:0] S32_MIN = -34'sh0_8000_0000;

    typedef struct packed {
        logic signed [31:0] g;
        logic signed [31:0] w;
        logic [31:0]        v;
        logic signed [48:0] prod;
        logic [31:0]        mag;
        logic [63:0]        sq;
        logic [31:0]        gsq;
        logic [47:0]        p1;
        logic [48:0]        p2;
        logic [31:0]        vn;
        logic [47:0]        xr;
        logic [26:0]        srem;
        logic [23:0]        root;
        logic [24:0]        den;
        logic               dzero;
        logic [47:0]        dn;
        logic [25:0]        drem;
        logic [47:0]        quo;
        logic signed [31:0] q;
        logic signed [48:0] step;
        logic signed [31:0] wn;
        logic               sat;
    } pl_t;

    function automatic pl_t stage_fn(input int idx, input pl_t p, input rmsu_pkg::cfg_t c);
        pl_t r;
        logic signed [33:0] sum34;
        logic [32:0] mag33;
        logic [49:0] vsum;
        logic [26:0] srem_sh;
        logic [26:0] trial;
        logic [25:0] drem_sh;
        logic [32:0] qm;
        logic [16:0] one_minus;
        r = p;
        if (idx == ST_PROD)
        begin
            r.prod = $signed({1'b0, c.l2_decay}) * p.w;
        end
        else if (idx == ST_DECAY)
        begin
            if (c.l2_decay == 16'd0)
                sum34 = 34'(p.g);
            else
                sum34 = 34'(p.g) + 34'(p.prod >>> rmsu_pkg::FRAC_BITS);
            if (sum34 > S32_MAX)
            begin
                r.g = S32_MAX[31:0];
                r.sat = 1'b1;
            end
            else if (sum34 < S32_MIN)
            begin
                r.g = S32_MIN[31:0];
                r.sat = 1'b1;
            end
            else
                r.g = sum34[31:0];
            if (r.g[31])
                mag33 = 33'd0 - {r.g[31], r.g};
            else
                mag33 = {1'b0, r.g};
            r.mag = mag33[31:0];
        end
        else if (idx == ST_SQ)
        begin
            r.sq = 64'(p.mag) * 64'(p.mag);
        end
        else if (idx == ST_GSQ)
        begin
            if (p.sq[63:48] != 16'd0)
            begin
                r.gsq = 32'hFFFF_FFFF;
                r.sat = 1'b1;
            end
            else
                r.gsq = p.sq[47:16];
        end
        else if (idx == ST_AVG)
        begin
            one_minus = 17'd65536 - {1'b0, c.decay_factor};
            r.p1 = 48'(c.decay_factor) * 48'(p.v);
            r.p2 = 49'(one_minus) * 49'(p.gsq);
        end
        else if (idx == ST_VN)
        begin
            vsum = 50'(p.p1) + 50'(p.p2);
            r.vn = vsum[47:16];
            r.xr = {vsum[47:16], 16'd0};
            r.srem = '0;
            r.root = '0;
        end
        else if (idx >= SQ_FIRST && idx < ST_DEN)
        begin
            srem_sh = {p.srem[24:0], p.xr[47:46]};
            trial = {1'b0, p.root, 2'b01};
            if (srem_sh >= trial)
            begin
                r.srem = srem_sh - trial;
                r.root = {p.root[22:0], 1'b1};
            end
            else
            begin
                r.srem = srem_sh;
                r.root = {p.root[22:0], 1'b0};
            end
            r.xr = {p.xr[45:0], 2'b00};
        end
        else if (idx == ST_DEN)
        begin
            r.den = 25'(p.root) + 25'(c.stability_eps);
            r.dzero = (p.root == 24'd0) && (c.stability_eps == 16'd0);
            r.dn = {p.mag, 16'd0};
            r.drem = '0;
            r.quo = '0;
        end
        else if (idx >= DIV_FIRST && idx < ST_Q)
        begin
            drem_sh = {p.drem[24:0], p.dn[47]};
            if (drem_sh >= 26'(p.den))
            begin
                r.drem = drem_sh - 26'(p.den);
                r.quo = {p.quo[46:0], 1'b1};
            end
            else
            begin
                r.drem = drem_sh;
                r.quo = {p.quo[46:0], 1'b0};
            end
            r.dn = {p.dn[46:0], 1'b0};
        end
        else if (idx == ST_Q)
        begin
            if (p.dzero)
            begin
                if (p.mag == 32'd0)
                    r.q = '0;
                else
                begin
                    r.q = p.g[31] ? S32_MIN[31:0] : S32_MAX[31:0];
                    r.sat = 1'b1;
                end
            end
            else
            begin
                if (p.quo > 48'h0000_8000_0000)
                    qm = 33'h0_8000_0000;
                else
                    qm = p.quo[32:0];
                if (p.g[31])
                    r.q = 32'(33'd0 - qm);
                else if (qm[31])
                begin
                    r.q = S32_MAX[31:0];
                    r.sat = 1'b1;
                end
                else
                    r.q = qm[31:0];
            end
        end
        else if (idx == ST_STEP)
        begin
            r.step = $signed({1'b0, c.learn_rate}) * p.q;
        end
        else
        begin
            sum34 = 34'(p.w) - 34'(p.step >>> rmsu_pkg::FRAC_BITS);
            if (sum34 > S32_MAX)
            begin
                r.wn = S32_MAX[31:0];
                r.sat = 1'b1;
            end
            else if (sum34 < S32_MIN)
            begin
                r.wn = S32_MIN[31:0];
                r.sat = 1'b1;
            end
            else
                r.wn = sum34[31:0];
        end
        return r;
    endfunction

    rmsu_pkg::cfg_t cfg_reg;
    pl_t  pipe_reg [NUM_STAGES];
    pl_t  pipe_next [NUM_STAGES];
    logic vld_reg [NUM_STAGES];
    logic en [NUM_STAGES];
    pl_t  in_pl;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.learn_rate <= rmsu_pkg::LEARN_RATE_RESET;
            cfg_reg.decay_factor <= rmsu_pkg::DECAY_FACTOR_RESET;
            cfg_reg.stability_eps <= rmsu_pkg::STABILITY_EPS_RESET;
            cfg_reg.l2_decay <= rmsu_pkg::L2_DECAY_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rmsu_pkg::REG_LEARN_RATE:    cfg_reg.learn_rate <= cfg_data;
                rmsu_pkg::REG_DECAY_FACTOR:  cfg_reg.decay_factor <= cfg_data;
                rmsu_pkg::REG_STABILITY_EPS: cfg_reg.stability_eps <= cfg_data;
                rmsu_pkg::REG_L2_DECAY:      cfg_reg.l2_decay <= cfg_data;
                default:                     cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        in_pl = '0;
        in_pl.g = in_data.gradient;
        in_pl.w = in_data.weight_in;
        in_pl.v = in_data.sq_avg_in;
    end

    genvar i;
    generate
        for (i = 0; i < NUM_STAGES; i++)
        begin : g_stage
            if (i == 0)
            begin : g_first
                assign pipe_next[i] = stage_fn(i, in_pl, cfg_reg);
            end
            else
            begin : g_rest
                assign pipe_next[i] = stage_fn(i, pipe_reg[i-1], cfg_reg);
            end
            if (i == NUM_STAGES - 1)
            begin : g_en_last
                assign en[i] = !vld_reg[i] || !out_stall;
            end
            else
            begin : g_en_mid
                assign en[i] = !vld_reg[i] || en[i+1];
            end
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_reg[i] <= 1'b0;
                else if (en[i])
                    vld_reg[i] <= (i == 0) ? in_valid : vld_reg[(i == 0) ? 0 : i-1];
            end
            always_ff @(posedge clk)
            begin
                if (en[i])
                    pipe_reg[i] <= pipe_next[i];
            end
        end
    endgenerate

    assign in_stall = !en[0];
    assign out_valid = vld_reg[NUM_STAGES-1];
    assign out_data.weight_out = pipe_reg[NUM_STAGES-1].wn;
    assign out_data.sq_avg_out = pipe_reg[NUM_STAGES-1].vn;
    assign out_data.saturated = pipe_reg[NUM_STAGES-1].sat;

    `RMSU_ASSERT_IMP(a_empty_out_ready, !out_valid, !in_stall)
    `RMSU_ASSERT_IMP(a_drain_ready, out_valid && !out_stall, !in_stall)
    `RMSU_ASSERT_NEXT(a_accept_fills, in_valid && !in_stall, vld_reg[0])

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// RMSprop element update testbench
// Streams requests through the element update datapath under random idling on
// both channels and compares every result with a built-in fixed-point predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 200;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    rmsu_pkg::in_t in_data;
    logic out_valid;
    logic out_stall;
    rmsu_pkg::out_t out_data;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [15:0] cfg_data;

    rmsu_pkg::cfg_t cur_cfg;
    rmsu_pkg::in_t pending_q[$];
    rmsu_pkg::out_t update_q[$];
    int errors;
    int results_seen;
    int accepted;
    int idle_cycles;
    bit quiet_phase;

    rmsprop_element_update u_top
    (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data(out_data),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    function automatic longint floor_shr16(longint x);
        return x >>> 16;
    endfunction

    function automatic longint clamp_s32(longint x, ref bit sat);
        if (x > 64'sd2147483647)
        begin
            sat = 1'b1;
            return 64'sd2147483647;
        end
        if (x < -64'sd2147483648)
        begin
            sat = 1'b1;
            return -64'sd2147483648;
        end
        return x;
    endfunction

    function automatic longint unsigned root_floor(longint unsigned x);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > x)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (x >= res + bitv)
            begin
                x = x - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic rmsu_pkg::out_t predict_update(rmsu_pkg::in_t req, rmsu_pkg::cfg_t c);
        rmsu_pkg::out_t r;
        bit sat;
        longint g;
        longint w;
        longint unsigned v;
        longint unsigned mag;
        longint unsigned gsq;
        longint unsigned vn;
        longint unsigned den;
        longint unsigned qm;
        longint q;
        longint stp;
        longint wn;
        sat = 1'b0;
        g = longint'(req.gradient);
        w = longint'(req.weight_in);
        v = {32'd0, req.sq_avg_in};
        if (c.l2_decay != 0)
            g = clamp_s32(g + floor_shr16(longint'({48'd0, c.l2_decay}) * w), sat);
        mag = longint'(g < 0 ? -g : g);
        gsq = (mag * mag) >> rmsu_pkg::FRAC_BITS;
        if (gsq > 64'hFFFF_FFFF)
        begin
            gsq = 64'hFFFF_FFFF;
            sat = 1'b1;
        end
        vn = ({48'd0, c.decay_factor} * v
              + (64'd65536 - {48'd0, c.decay_factor}) * gsq) >> 16;
        den = root_floor(vn << rmsu_pkg::FRAC_BITS) + {48'd0, c.stability_eps};
        if (den == 0)
        begin
            if (g == 0)
                q = 0;
            else
            begin
                q = g < 0 ? -64'sd2147483648 : 64'sd2147483647;
                sat = 1'b1;
            end
        end
        else
        begin
            qm = (mag << rmsu_pkg::FRAC_BITS) / den;
            if (qm > 64'd2147483648)
                qm = 64'd2147483648;
            q = g < 0 ? -longint'(qm) : longint'(qm);
            q = clamp_s32(q, sat);
        end
        stp = floor_shr16(longint'({48'd0, c.learn_rate}) * q);
        wn = clamp_s32(w - stp, sat);
        r.weight_out = wn[31:0];
        r.sq_avg_out = vn[31:0];
        r.saturated = sat;
        return r;
    endfunction

    function automatic logic [31:0] rand_word(int mode);
        case (mode)
            0: return $urandom;
            1: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
            2: return $urandom_range(0, 32'h0000_0400);
            default: return 32'h8000_0000 ^ $urandom_range(0, 3);
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data <= '0;
            out_stall <= 1'b0;
        end
        else
        begin
            if (!in_valid || !in_stall)
            begin
                if (pending_q.size() > 0 && (quiet_phase || $urandom_range(0, 99) >= 20))
                begin
                    in_valid <= 1'b1;
                    in_data <= pending_q.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
            out_stall <= quiet_phase ? 1'b0 : ($urandom_range(0, 99) < 20);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                update_q = {update_q, predict_update(in_data, cur_cfg)};
                accepted++;
            end
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (update_q.size() == 0)
                begin
                    $display("%0t: unexpected result %h", $time, out_data);
                    errors++;
                end
                else
                begin
                    rmsu_pkg::out_t exp_r;
                    exp_r = update_q.pop_front();
                    if (exp_r.weight_out !== out_data.weight_out)
                    begin
                        $display("%0t: weight_out expected %h actual %h", $time,
                                 exp_r.weight_out, out_data.weight_out);
                        errors++;
                    end
                    if (exp_r.sq_avg_out !== out_data.sq_avg_out)
                    begin
                        $display("%0t: sq_avg_out expected %h actual %h", $time,
                                 exp_r.sq_avg_out, out_data.sq_avg_out);
                        errors++;
                    end
                    if (exp_r.saturated !== out_data.saturated)
                    begin
                        $display("%0t: saturated expected %b actual %b", $time,
                                 exp_r.saturated, out_data.saturated);
                        errors++;
                    end
                end
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Watchdog expired with %0d results outstanding", update_q.size());
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            rmsu_pkg::REG_LEARN_RATE: cur_cfg.learn_rate = val;
            rmsu_pkg::REG_DECAY_FACTOR: cur_cfg.decay_factor = val;
            rmsu_pkg::REG_STABILITY_EPS: cur_cfg.stability_eps = val;
            default: cur_cfg.l2_decay = val;
        endcase
    endtask

    task automatic wait_drained();
        while (pending_q.size() > 0 || in_valid || update_q.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic push_req(logic [31:0] g, logic [31:0] w, logic [31:0] v);
        rmsu_pkg::in_t req;
        req.gradient = g;
        req.weight_in = w;
        req.sq_avg_in = v;
        pending_q = {pending_q, req};
    endtask

    initial
    begin
        logic [31:0] edge_vals[6];
        int m;
        errors = 0;
        results_seen = 0;
        accepted = 0;
        idle_cycles = 0;
        quiet_phase = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = rmsu_pkg::REG_LEARN_RATE;
        cfg_data = '0;
        cur_cfg.learn_rate = rmsu_pkg::LEARN_RATE_RESET;
        cur_cfg.decay_factor = rmsu_pkg::DECAY_FACTOR_RESET;
        cur_cfg.stability_eps = rmsu_pkg::STABILITY_EPS_RESET;
        cur_cfg.l2_decay = rmsu_pkg::L2_DECAY_RESET;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        edge_vals = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000};
        for (int i = 0; i < 6; i++)
            push_req(edge_vals[i], edge_vals[(i + 2) % 6], edge_vals[(i + 4) % 6]);
        push_req(32'h0, 32'h1234_5678, 32'h0);
        push_req(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
        push_req(32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
        wait_drained();

        // Zero root and epsilon, with weight decay pushing the gradient out of range.
        write_reg(rmsu_pkg::REG_STABILITY_EPS, 16'd0);
        write_reg(rmsu_pkg::REG_DECAY_FACTOR, 16'hFFFF);
        write_reg(rmsu_pkg::REG_L2_DECAY, 16'hFFFF);
        write_reg(rmsu_pkg::REG_LEARN_RATE, 16'hFFFF);
        push_req(32'h0, 32'h0, 32'h0);
        push_req(32'h0000_0100, 32'h0, 32'h0);
        push_req(32'hFFFF_FF00, 32'h0, 32'h0);
        push_req(32'h7FFF_0000, 32'h7FFF_FFFF, 32'h0);
        push_req(32'h8000_0000, 32'h8000_0000, 32'h0);
        push_req(32'h0000_0001, 32'h8000_0000, 32'h0);
        wait_drained();
        write_reg(rmsu_pkg::REG_DECAY_FACTOR, 16'd0);

        for (int phase = 0; phase < 8; phase++)
        begin
            if (phase > 0)
            begin
                write_reg(rmsu_pkg::REG_LEARN_RATE, phase == 7 ? 16'd0 : 16'($urandom));
                write_reg(rmsu_pkg::REG_DECAY_FACTOR, phase == 6 ? 16'hFFFF : 16'($urandom));
                write_reg(rmsu_pkg::REG_STABILITY_EPS,
                          phase == 5 ? 16'd0 : 16'($urandom_range(0, 300)));
                write_reg(rmsu_pkg::REG_L2_DECAY, phase % 2 ? 16'd0 : 16'($urandom));
            end
            quiet_phase = (phase == 3);
            for (int i = 0; i < 235; i++)
            begin
                m = $urandom_range(0, 3);
                push_req(rand_word(m), rand_word($urandom_range(0, 3)),
                         rand_word($urandom_range(0, 2)));
            end
            wait_drained();
        end

        $display("Ran %0d requests through %0d register settings, %0d results checked.",
                 accepted, 10, results_seen);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== rmsprop_element_update.f =====
+incdir+design
design/rmsu_pkg.sv
design/rmsprop_element_update.sv
tb/sv/testbench.sv
